[hw/rtl/rbd_pkg.sv]
// ----------------------------------------------------------------------------
// rbd_pkg: shared types and constants of the RGB box downscaler
// Pixel and sum widths, row phase codes, the lane control word and the
// rounded pair average used by every colour lane.
// ----------------------------------------------------------------------------
package rbd_pkg;

    // Field widths fixed by the pixel format and the register.
    localparam int PIX_W          = 8;
    localparam int SUM_W          = 10;
    localparam int CFG_W          = 12;

    // Default line store depth and the width after reset.
    localparam int MAX_WIDTH_DEF  = 2048;
    localparam logic [CFG_W-1:0] LINE_WIDTH_RST = 12'd640;

    // Block size; the column phase is taken from the low bits of the count.
    localparam int SCALE          = 4;

    // Row phase within a group of four rows.
    localparam logic [1:0] PH_ROW0 = 2'd0;  // store row 0
    localparam logic [1:0] PH_ROW1 = 2'd1;  // fold row 1 into the pair average
    localparam logic [1:0] PH_ROW2 = 2'd2;  // store row 2
    localparam logic [1:0] PH_ROW3 = 2'd3;  // combine and accumulate

    // Control word handed from the sequencer to each colour lane.
    typedef struct packed {
        logic       rd_en;   // read the line stores for the word just taken
        logic       step;    // the word in the second stage completes
        logic [1:0] phase;   // row phase of the word in the second stage
        logic       clear;   // clear the running sum after this word
    } t_lane_ctl;

    // Rounded average of two pixel values.
    function automatic logic [PIX_W-1:0] avg2(input logic [PIX_W-1:0] a,
                                              input logic [PIX_W-1:0] b);
        logic [PIX_W:0] s;
        s = {1'b0, a} + {1'b0, b} + {{PIX_W{1'b0}}, 1'b1};
        return s[PIX_W:1];
    endfunction

endpackage

[hw/rtl/rgb_box_downscale_by_four.sv]
// A taken word waits in the second stage, then any result goes to the output register.
// Throughput: one pixel per clock while not stalled, bounded by the single read of
// each line store. A stalled output holds the next word that carries a result in the
// second stage, and with it the input.
// Reset is synchronous and active low; it clears the counters, sums and valids.
// The line stores are not cleared and need no clearing pass after reset.
// ----------------------------------------------------------------------------
// rgb_box_downscale_by_four: 4x4 box downscaler for an RGB raster stream
// Column and row sequencer with three colour lanes working side by side
// and an output register that merges the lane results into one word.
// ----------------------------------------------------------------------------
module rgb_box_downscale_by_four #(
    parameter int MAX_WIDTH = rbd_pkg::MAX_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_line_width_we,
    input  logic [rbd_pkg::CFG_W-1:0]       i_line_width,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [rbd_pkg::PIX_W-1:0]       i_in_red,
    input  logic [rbd_pkg::PIX_W-1:0]       i_in_green,
    input  logic [rbd_pkg::PIX_W-1:0]       i_in_blue,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [rbd_pkg::PIX_W-1:0]       o_out_red,
    output logic [rbd_pkg::PIX_W-1:0]       o_out_green,
    output logic [rbd_pkg::PIX_W-1:0]       o_out_blue,
    output logic                            o_row_end
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = (CW + 1 > rbd_pkg::CFG_W) ? CW + 1 : rbd_pkg::CFG_W;
    localparam logic [WW-1:0] WIDTH_CAP = WW'((MAX_WIDTH / 4) * 4);
    localparam logic [WW-1:0] WIDTH_MIN = WW'(rbd_pkg::SCALE);
    localparam int NL = 3;

    logic [rbd_pkg::CFG_W-1:0] r_line_width;
    logic [CW-1:0]             r_col;
    logic [1:0]                r_phase;
    logic [WW-1:0]             w_raw;
    logic [WW-1:0]             w_clip;
    logic [WW-1:0]             w_align;
    logic [WW-1:0]             w_act;
    logic                      accept;
    logic                      last;
    logic                      emit;
    logic [CW-1:0]             n_col;
    logic [1:0]                n_phase;

    logic                      r_s1_valid;
    logic [CW-1:0]             r_s1_col;
    logic [1:0]                r_s1_phase;
    logic                      r_s1_emit;
    logic                      r_s1_last;
    logic [rbd_pkg::PIX_W-1:0] r_s1_px [NL];
    logic                      s1_step;

    logic                      r_out_valid;
    logic [rbd_pkg::PIX_W-1:0] r_out_val [NL];
    logic                      r_out_row_end;

    rbd_pkg::t_lane_ctl        lane_ctl;
    logic [rbd_pkg::PIX_W-1:0] lane_val [NL];

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width <= rbd_pkg::LINE_WIDTH_RST;
        end else if (i_line_width_we) begin
            r_line_width <= i_line_width;
        end
    end

    // Active width: capped at the store depth, rounded down to four, at least four.
    assign w_raw   = WW'(r_line_width);
    assign w_clip  = (w_raw > WIDTH_CAP) ? WIDTH_CAP : w_raw;
    assign w_align = {w_clip[WW-1:2], 2'b00};
    assign w_act   = (w_align < WIDTH_MIN) ? WIDTH_MIN : w_align;

    // Handshake: the second stage completes unless its result finds the output full.
    assign s1_step = r_s1_valid && !(r_s1_emit && r_out_valid && !i_ready);
    assign o_ready = !r_s1_valid || s1_step;
    assign accept  = i_valid && o_ready;

    // Column and row sequencing for the word at the input.
    assign last    = (WW'(r_col) + WW'(1)) >= w_act;
    assign emit    = (r_phase == rbd_pkg::PH_ROW3) && (r_col[1:0] == 2'(rbd_pkg::SCALE - 1));
    assign n_col   = last ? '0 : r_col + CW'(1);
    assign n_phase = last ? r_phase + 2'd1 : r_phase;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_phase <= rbd_pkg::PH_ROW0;
        end else if (accept) begin
            r_col   <= n_col;
            r_phase <= n_phase;
        end
    end

    // Second stage: the word waits here while the line stores are read.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_step) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_col   <= r_col;
            r_s1_phase <= r_phase;
            r_s1_emit  <= emit;
            r_s1_last  <= last;
            r_s1_px[0] <= i_in_red;
            r_s1_px[1] <= i_in_green;
            r_s1_px[2] <= i_in_blue;
        end
    end

    // Colour lanes.
    assign lane_ctl.rd_en = accept;
    assign lane_ctl.step  = s1_step;
    assign lane_ctl.phase = r_s1_phase;
    assign lane_ctl.clear = r_s1_emit || r_s1_last;

    for (genvar g = 0; g < NL; g++) begin : g_lane
        rbd_lane #(
            .MAX_WIDTH (MAX_WIDTH)
        ) u_lane (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctl     (lane_ctl),
            .i_rd_addr (r_col),
            .i_wr_addr (r_s1_col),
            .i_px      (r_s1_px[g]),
            .o_val     (lane_val[g])
        );
    end

    // Output register: merges the three lane results into one word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_step && r_s1_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_step && r_s1_emit) begin
            r_out_val[0]  <= lane_val[0];
            r_out_val[1]  <= lane_val[1];
            r_out_val[2]  <= lane_val[2];
            r_out_row_end <= r_s1_last;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_out_red   = r_out_val[0];
    assign o_out_green = r_out_val[1];
    assign o_out_blue  = r_out_val[2];
    assign o_row_end   = r_out_row_end;

`ifndef SYNTHESIS
    // The column count always addresses an entry of the line stores.
    a_col_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_col) < MAX_WIDTH)
        else $error("column count beyond line store depth");

    // A result is only ever formed in the fourth row of a group.
    a_emit_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_s1_emit) |-> (r_s1_phase == rbd_pkg::PH_ROW3))
        else $error("result formed outside the fourth row");

    // Taking the last word of a row starts the next row at column zero.
    a_row_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && last) |=> (r_col == '0 && r_phase == $past(r_phase) + 2'd1))
        else $error("row end did not restart the column count");
`endif

endmodule

[hw/rtl/rbd_ram.sv]
// ----------------------------------------------------------------------------
// rbd_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data, which holds
// while the read enable is low.
// ----------------------------------------------------------------------------
module rbd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/rbd_lane.sv]
// ----------------------------------------------------------------------------
// rbd_lane: one colour lane of the downscaler
// Holds the two line stores of its colour, forms the vertical average of
// four rows per column and keeps the running sum over four columns.
// ----------------------------------------------------------------------------
module rbd_lane #(
    parameter int MAX_WIDTH = rbd_pkg::MAX_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  rbd_pkg::t_lane_ctl           i_ctl,
    input  logic [$clog2(MAX_WIDTH)-1:0] i_rd_addr,
    input  logic [$clog2(MAX_WIDTH)-1:0] i_wr_addr,
    input  logic [rbd_pkg::PIX_W-1:0]    i_px,
    output logic [rbd_pkg::PIX_W-1:0]    o_val
);

    logic [rbd_pkg::PIX_W-1:0] pair_rd;
    logic [rbd_pkg::PIX_W-1:0] third_rd;
    logic [rbd_pkg::PIX_W-1:0] pair_wdata;
    logic [rbd_pkg::PIX_W-1:0] vert;
    logic                      pair_we;
    logic                      third_we;
    logic [rbd_pkg::SUM_W-1:0] sum_add;
    logic [rbd_pkg::SUM_W-1:0] r_sum;
    logic [rbd_pkg::SUM_W-1:0] n_sum;

    // Line store for row 0, then the rounded average of rows 0 and 1.
    rbd_ram #(
        .WIDTH (rbd_pkg::PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_pair_line (
        .i_clk   (i_clk),
        .i_we    (pair_we),
        .i_waddr (i_wr_addr),
        .i_wdata (pair_wdata),
        .i_re    (i_ctl.rd_en),
        .i_raddr (i_rd_addr),
        .o_rdata (pair_rd)
    );

    // Line store for row 2.
    rbd_ram #(
        .WIDTH (rbd_pkg::PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_third_line (
        .i_clk   (i_clk),
        .i_we    (third_we),
        .i_waddr (i_wr_addr),
        .i_wdata (i_px),
        .i_re    (i_ctl.rd_en),
        .i_raddr (i_rd_addr),
        .o_rdata (third_rd)
    );

    // Store writes for the first three rows of a group.
    assign pair_we    = i_ctl.step &&
                        (i_ctl.phase == rbd_pkg::PH_ROW0 || i_ctl.phase == rbd_pkg::PH_ROW1);
    assign third_we   = i_ctl.step && (i_ctl.phase == rbd_pkg::PH_ROW2);
    assign pair_wdata = (i_ctl.phase == rbd_pkg::PH_ROW1) ? rbd_pkg::avg2(pair_rd, i_px)
                                                          : i_px;

    // Vertical average of the four rows and the running column sum.
    assign vert    = rbd_pkg::avg2(pair_rd, rbd_pkg::avg2(third_rd, i_px));
    assign sum_add = r_sum + {{(rbd_pkg::SUM_W - rbd_pkg::PIX_W){1'b0}}, vert};
    assign o_val   = sum_add[rbd_pkg::SUM_W-1:2];

    always_comb begin
        n_sum = r_sum;
        if (i_ctl.step) begin
            if (i_ctl.clear) begin
                n_sum = '0;
            end else if (i_ctl.phase == rbd_pkg::PH_ROW3) begin
                n_sum = sum_add;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
        end else begin
            r_sum <= n_sum;
        end
    end

endmodule

[tb/rbd_downscale_checker.sv]
// ----------------------------------------------------------------------------
// rbd_downscale_checker: scoreboard for the RGB box downscaler
// Watches the register port and both word channels, folds every accepted
// pixel into its own copy of the line stores and running sums, and compares
// each downscaled word against the oldest one awaited, field by field.
// ----------------------------------------------------------------------------
module rbd_downscale_checker #(
    parameter int MAX_WIDTH = rbd_pkg::MAX_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [rbd_pkg::CFG_W-1:0]   i_cfg_width,
    input  logic                        i_in_valid,
    input  logic                        i_in_ready,
    input  logic [rbd_pkg::PIX_W-1:0]   i_in_red,
    input  logic [rbd_pkg::PIX_W-1:0]   i_in_green,
    input  logic [rbd_pkg::PIX_W-1:0]   i_in_blue,
    input  logic                        i_out_valid,
    input  logic                        i_out_ready,
    input  logic [rbd_pkg::PIX_W-1:0]   i_out_red,
    input  logic [rbd_pkg::PIX_W-1:0]   i_out_green,
    input  logic [rbd_pkg::PIX_W-1:0]   i_out_blue,
    input  logic                        i_out_row_end,
    output int                          o_fail_count,
    output int                          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import rbd_pkg::*;

    // Colour channel positions within a packed pixel.
    localparam int CH_RED   = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE  = 2;
    localparam int CHANNELS = 3;

    typedef logic [CHANNELS-1:0][PIX_W-1:0] t_rgb;

    typedef struct packed {
        t_rgb chan;
        logic row_end;
    } t_scaled_word;

    // Own copy of the block state.
    t_rgb                          pair_line  [MAX_WIDTH];
    t_rgb                          third_line [MAX_WIDTH];
    logic [CHANNELS-1:0][SUM_W-1:0] box_sums;
    logic [CFG_W-1:0]              width_reg;
    logic [1:0]                    phase;
    int unsigned                   column;

    t_scaled_word awaited_pixels [$];
    int           mismatch_count = 0;
    int           pending_count  = 0;

    assign o_fail_count = mismatch_count;
    assign o_pending    = pending_count;

    // Rounded mean of two pixel values, halves going up.
    function automatic logic [PIX_W-1:0] half_up_mean(input logic [PIX_W-1:0] a,
                                                      input logic [PIX_W-1:0] b);
        int total;
        total = int'(a) + int'(b) + 1;
        return PIX_W'(total >> 1);
    endfunction

    // Row length in force: low bits dropped, held within four and the store depth.
    function automatic int unsigned active_columns(input logic [CFG_W-1:0] raw);
        int unsigned cols;
        cols = int'(raw);
        if (cols > MAX_WIDTH) begin
            cols = MAX_WIDTH;
        end
        cols = (cols / SCALE) * SCALE;
        if (cols < SCALE) begin
            cols = SCALE;
        end
        return cols;
    endfunction

    function automatic string channel_name(input int ch);
        case (ch)
            CH_RED:   return "out_red";
            CH_GREEN: return "out_green";
            default:  return "out_blue";
        endcase
    endfunction

    // Folds one accepted pixel into the box and queues a result on the last
    // column of a block in the last row of a group.
    task automatic fold_into_box(input t_rgb px);
        int unsigned  col_idx;
        logic         row_done;
        t_scaled_word want;
        int           ch;
        col_idx  = (column >= MAX_WIDTH) ? MAX_WIDTH - 1 : column;
        row_done = (column + 1 >= active_columns(width_reg));
        for (ch = 0; ch < CHANNELS; ch++) begin
            case (phase)
                PH_ROW0: pair_line[col_idx][ch] = px[ch];
                PH_ROW1: pair_line[col_idx][ch] =
                    half_up_mean(pair_line[col_idx][ch], px[ch]);
                PH_ROW2: third_line[col_idx][ch] = px[ch];
                default: box_sums[ch] = box_sums[ch] + SUM_W'(half_up_mean(
                    pair_line[col_idx][ch], half_up_mean(third_line[col_idx][ch], px[ch])));
            endcase
        end
        if (phase == PH_ROW3 && (column % SCALE) == SCALE - 1) begin
            for (ch = 0; ch < CHANNELS; ch++) begin
                want.chan[ch] = box_sums[ch][SUM_W-1:2];
            end
            want.row_end = row_done;
            awaited_pixels.push_back(want);
            box_sums = '0;
        end
        // A row ends at the last column or wherever a narrower width leaves it.
        if (row_done) begin
            column   = 0;
            phase    = phase + 2'd1;
            box_sums = '0;
        end else begin
            column = column + 1;
        end
    endtask

    // Compares one downscaled word with the oldest one awaited.
    task automatic check_scaled_word();
        t_scaled_word want;
        t_rgb         got;
        int           ch;
        got = {i_out_blue, i_out_green, i_out_red};
        if (awaited_pixels.size() == 0) begin
            $error("unexpected word: out_red %0d out_green %0d out_blue %0d row_end %0d",
                   i_out_red, i_out_green, i_out_blue, i_out_row_end);
            mismatch_count++;
        end else begin
            want = awaited_pixels.pop_front();
            for (ch = 0; ch < CHANNELS; ch++) begin
                if (got[ch] !== want.chan[ch]) begin
                    $error("%s mismatch: expected %0d, actual %0d",
                           channel_name(ch), want.chan[ch], got[ch]);
                    mismatch_count++;
                end
            end
            if (i_out_row_end !== want.row_end) begin
                $error("row_end mismatch: expected %0d, actual %0d",
                       want.row_end, i_out_row_end);
                mismatch_count++;
            end
        end
    endtask

    // Sample both channels and the register port at every edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            width_reg = LINE_WIDTH_RST;
            column    = 0;
            phase     = PH_ROW0;
            box_sums  = '0;
            awaited_pixels.delete();
        end else begin
            if (i_cfg_we) begin
                width_reg = i_cfg_width;
            end
            if (i_in_valid && i_in_ready) begin
                fold_into_box({i_in_blue, i_in_green, i_in_red});
            end
            if (i_out_valid && i_out_ready) begin
                check_scaled_word();
            end
        end
        pending_count = awaited_pixels.size();
    end

endmodule

[tb/rgb_box_downscale_by_four_tb.sv]
// ----------------------------------------------------------------------------
// rgb_box_downscale_by_four_tb: stimulus and verdict for the RGB box downscaler
// Drives pixel words in raster order over groups of four rows at many row
// widths, changes the width between groups and part way through rows, and
// varies idling on both channels; the checker beside the block does the
// prediction and comparison.
// ----------------------------------------------------------------------------
module rgb_box_downscale_by_four_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rbd_pkg::*;

    localparam int LINE_MAX      = MAX_WIDTH_DEF;
    localparam int CYCLE_LIMIT   = 500_000;
    localparam int LONG_HOLD     = 200;
    localparam int SETTLE_CYCLES = 6;
    localparam int MIX_ITEMS     = 350;
    localparam int WIDE_CUT      = 8 * SCALE;

    localparam logic [PIX_W-1:0] LEVEL_MIN = '0;
    localparam logic [PIX_W-1:0] LEVEL_MAX = '1;

    logic             i_clk           = 1'b0;
    logic             i_rst_n         = 1'b0;
    logic             i_line_width_we = 1'b0;
    logic [CFG_W-1:0] i_line_width    = '0;
    logic             i_valid         = 1'b0;
    logic             o_ready;
    logic [PIX_W-1:0] i_in_red        = '0;
    logic [PIX_W-1:0] i_in_green      = '0;
    logic [PIX_W-1:0] i_in_blue       = '0;
    logic             o_valid;
    logic             i_ready         = 1'b0;
    logic [PIX_W-1:0] o_out_red;
    logic [PIX_W-1:0] o_out_green;
    logic [PIX_W-1:0] o_out_blue;
    logic             o_row_end;

    int fail_count;
    int pending;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_requests = 0;
    int holds_served  = 0;
    int hold_left     = 0;
    int pixels_sent   = 0;
    int cycle_count   = 0;

    rgb_box_downscale_by_four #(
        .MAX_WIDTH(LINE_MAX)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_line_width_we(i_line_width_we),
        .i_line_width   (i_line_width),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_in_red       (i_in_red),
        .i_in_green     (i_in_green),
        .i_in_blue      (i_in_blue),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_out_red      (o_out_red),
        .o_out_green    (o_out_green),
        .o_out_blue     (o_out_blue),
        .o_row_end      (o_row_end)
    );

    rbd_downscale_checker #(
        .MAX_WIDTH(LINE_MAX)
    ) checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_line_width_we),
        .i_cfg_width  (i_line_width),
        .i_in_valid   (i_valid),
        .i_in_ready   (o_ready),
        .i_in_red     (i_in_red),
        .i_in_green   (i_in_green),
        .i_in_blue    (i_in_blue),
        .i_out_valid  (o_valid),
        .i_out_ready  (i_ready),
        .i_out_red    (o_out_red),
        .i_out_green  (o_out_green),
        .i_out_blue   (o_out_blue),
        .i_out_row_end(o_row_end),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Clock with a 2 ns period.
    always #1ns i_clk = ~i_clk;

    // Run limit in case the block hangs.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Receiver: random back-pressure, or a long hold when one is requested.
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            i_ready   <= 1'b0;
            hold_left = hold_left - 1;
        end else if (hold_requests != holds_served) begin
            holds_served = hold_requests;
            hold_left    = LONG_HOLD - 1;
            i_ready      <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Channel value biased towards the extremes.
    function automatic logic [PIX_W-1:0] pick_level();
        case ($urandom_range(7))
            0:       return LEVEL_MIN;
            1:       return LEVEL_MAX;
            default: return PIX_W'($urandom_range(255));
        endcase
    endfunction

    // Mostly narrow rows, now and then a wider one.
    function automatic int pick_cols();
        if ($urandom_range(19) == 0) begin
            return SCALE * $urandom_range(64, 17);
        end
        return SCALE * $urandom_range(16, 1);
    endfunction

    // Register value for a row length, with junk in the two low bits.
    function automatic logic [CFG_W-1:0] raw_for(input int cols);
        return CFG_W'(cols + $urandom_range(3));
    endfunction

    // Offers one pixel word and returns at the edge that takes it.
    task automatic send_pixel(input logic [PIX_W-1:0] red,
                              input logic [PIX_W-1:0] green,
                              input logic [PIX_W-1:0] blue);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_in_red   <= red;
        i_in_green <= green;
        i_in_blue  <= blue;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        pixels_sent++;
    endtask

    task automatic send_run(input int count);
        int k;
        for (k = 0; k < count; k++) begin
            send_pixel(pick_level(), pick_level(), pick_level());
        end
    endtask

    // Stops offering, waits for every awaited word and lets the pipeline empty.
    task automatic settle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        wait (pending == 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Register writes only ever happen with the block idle.
    task automatic write_width(input logic [CFG_W-1:0] raw);
        settle();
        i_line_width_we <= 1'b1;
        i_line_width    <= raw;
        @(posedge i_clk);
        i_line_width_we <= 1'b0;
    endtask

    // Whole groups of four rows at one width.
    task automatic send_groups(input logic [CFG_W-1:0] raw, input int cols,
                               input int groups);
        write_width(raw);
        send_run(SCALE * cols * groups);
    endtask

    // Width change part way through the first row of a group. A narrower
    // width ends the row at the next word; the later rows use the new width.
    task automatic cut_first_row(input int old_cols, input int cut, input int new_cols);
        write_width(raw_for(old_cols));
        send_run(cut);
        write_width(raw_for(new_cols));
        send_run(((cut + 1 > new_cols) ? cut + 1 : new_cols) - cut);
        send_run((SCALE - 1) * new_cols);
    endtask

    // Width drop part way through the last row of a group, so the row may
    // end early with a flagged word.
    task automatic cut_last_row(input int cols, input int cut, input int new_cols);
        write_width(raw_for(cols));
        send_run((SCALE - 1) * cols + cut);
        write_width(raw_for(new_cols));
        send_run(((cut + 1 > new_cols) ? cut + 1 : new_cols) - cut);
    endtask

    // Random mix of whole groups and mid-row width changes; every step
    // leaves the stream at the start of a group.
    task automatic run_mix(input int stop_at);
        int cols;
        int cut;
        while (pixels_sent < stop_at) begin
            cols = pick_cols();
            cut  = $urandom_range(cols - 1, 1);
            case ($urandom_range(9))
                0:       cut_first_row(cols, cut, pick_cols());
                1:       cut_last_row(cols, cut, SCALE * $urandom_range(cols / SCALE, 1));
                default: send_groups(raw_for(cols), cols, $urandom_range(3, 1));
            endcase
        end
    endtask

    initial begin
        int r;
        int c;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Two words at the reset width, then a width below range that clears
        // to zero and is raised to four, which finishes the row there.
        send_pixel(LEVEL_MAX, LEVEL_MIN, LEVEL_MAX);
        send_pixel(LEVEL_MIN, LEVEL_MAX, LEVEL_MIN);
        write_width(CFG_W'(1));
        // Rest of one block with full and empty channels; the blue checker pattern makes
        // the averages of rows 2 and 3, and of rows 0 and 1 in columns 2 and 3, round up.
        for (r = 0; r < SCALE; r++) begin
            for (c = 0; c < SCALE; c++) begin
                if (r != 0 || c >= 2) begin
                    send_pixel(LEVEL_MAX, LEVEL_MIN,
                               ((r + c) % 2 == 1) ? LEVEL_MAX : LEVEL_MIN);
                end
            end
        end

        // Slow receiver. First a long hold while words keep coming at full
        // rate, so the block fills up and stalls its input.
        send_idle_pct = 27;
        recv_idle_pct = 75;
        write_width(raw_for(SCALE));
        send_idle_pct = 0;
        hold_requests++;
        send_run(3 * SCALE * SCALE);
        send_idle_pct = 27;
        run_mix(pixels_sent + MIX_ITEMS);

        // Slow sender; a zero width is raised to the minimum.
        send_idle_pct = 75;
        recv_idle_pct = 27;
        send_groups('0, SCALE, 1);
        run_mix(pixels_sent + MIX_ITEMS);

        // No idling on either side, then a first row opened with a value above
        // range, which is capped rather than ending the row early, and cut to
        // the minimum width part way through.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_mix(pixels_sent + MIX_ITEMS);
        write_width('1);
        send_run(WIDE_CUT);
        write_width(raw_for(SCALE));
        send_run(1 + (SCALE - 1) * SCALE);

        settle();
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

[sim.f]
hw/rtl/rbd_pkg.sv
hw/rtl/rbd_ram.sv
hw/rtl/rbd_lane.sv
hw/rtl/rgb_box_downscale_by_four.sv
tb/rbd_downscale_checker.sv
tb/rgb_box_downscale_by_four_tb.sv
